// File: rtl/core/ales_pkg.sv
// ales_pkg: shared codes and field widths for the adjacency list edge store
// no dependencies; imported by adjacency_list_edge_store
`timescale 1ns / 1ps

package ales_pkg;

  // field widths fixed by the item format
  localparam int VTX_W    = 6;
  localparam int WT_W     = 32;
  localparam int HIT_W    = 7;
  localparam int TOTAL_W  = 10;
  localparam int VCNT_W   = 7;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // item modes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  localparam logic [VCNT_W-1:0]  VCNT_RESET = 7'd64;
  localparam logic [HIT_W-1:0]   HIT_NONE   = 7'h7F;

  // one neighbor list entry as kept in the store
  typedef struct packed {
    logic [WT_W-1:0]  wt;
    logic [VTX_W-1:0] nbr;
  } entry_t;

endpackage

// File: rtl/core/adjacency_list_edge_store.sv
// adjacency_list_edge_store: undirected weighted edge store, bounded neighbor lists
// depends on ales_pkg (codes, widths, entry type)
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// --------  ---  -----------------  ---------------------------------------------------
// s_*       in   s_tvalid/s_tready  tuser: mode; tdata: from, to, weight
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: hit_from, hit_to, hit_weight,
//                                   edge_total
// cfg_*     in   cfg_wr_en          vertex_count, no read-back
//
// one item at a time; one neighbor memory and one entry comparator do all list work
// add appends an entry to both lists; lookup scans the from list entry by entry;
// remove scans and shifts over both lists; clear sweeps the length memory one vertex
// a cycle; s_tready the cycle after the result is loaded
// after reset the same sweep runs before s_tready rises
// a waiting result only holds back the hand-off of the next item's result

module adjacency_list_edge_store #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // vertex_count
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,       // mode
  input  logic [47:0] s_tdata,       // from_vertex[5:0], to_vertex[11:6], weight[43:12], zero
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,       // status
  output logic [55:0] m_tdata        // hit_from[6:0], hit_to[13:7], hit_weight[45:14],
                                     // edge_total[55:46]
);

  import ales_pkg::*;

  // widths that follow from the parameters
  localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;  // vertex index
  localparam int DW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;      // slot index
  localparam int LW   = $clog2(MAX_DEGREE + 1);                         // list length
  localparam int XW   = (VW > VTX_W) ? VW : VTX_W;                      // widened vertex
  localparam int LIMW = ($clog2(MAX_VERTICES + 1) > VCNT_W) ?
                        $clog2(MAX_VERTICES + 1) : VCNT_W;              // range limit
  localparam int NROW = MAX_VERTICES * (2 ** DW);                       // store depth

  // sequencer states
  localparam logic [3:0] S_CLR       = 4'd0;   // length sweep (reset or clear)
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_LEN_A     = 4'd2;   // read length of from
  localparam logic [3:0] S_LEN_B     = 4'd3;   // read length of to
  localparam logic [3:0] S_DISPATCH  = 4'd4;
  localparam logic [3:0] S_ADD_A     = 4'd5;
  localparam logic [3:0] S_ADD_B     = 4'd6;
  localparam logic [3:0] S_SCAN_RD   = 4'd7;
  localparam logic [3:0] S_SCAN_CHK  = 4'd8;
  localparam logic [3:0] S_SHIFT_RD  = 4'd9;
  localparam logic [3:0] S_SHIFT_WR  = 4'd10;
  localparam logic [3:0] S_NEXT_LIST = 4'd11;
  localparam logic [3:0] S_RESULT    = 4'd12;

  // input item fields
  logic [VTX_W-1:0] in_from;
  logic [VTX_W-1:0] in_to;
  logic [WT_W-1:0]  in_wt;
  assign in_from = s_tdata[5:0];
  assign in_to   = s_tdata[11:6];
  assign in_wt   = s_tdata[43:12];

  // control state
  logic [3:0]          state;
  logic [VCNT_W-1:0]   vertex_count;
  logic [TOTAL_W-1:0]  edge_cnt;
  logic [VW-1:0]       clr_idx;
  logic                clr_item;     // sweep belongs to a clear item
  logic                pass;         // 0: list of from, 1: list of to
  logic                removed;      // at least one entry erased
  logic                hit_found;

  // item and working registers
  logic [MODE_W-1:0]   item_mode;
  logic [VTX_W-1:0]    item_from;
  logic [VTX_W-1:0]    item_to;
  logic [WT_W-1:0]     item_wt;
  logic [STATUS_W-1:0] item_status;
  logic [LW-1:0]       len_a;
  logic [LW-1:0]       len_b;
  logic [LW-1:0]       list_n;
  logic [LW-1:0]       idx;
  logic [WT_W-1:0]     hit_w;

  // result register
  logic [STATUS_W-1:0] res_status;
  logic [HIT_W-1:0]    res_from;
  logic [HIT_W-1:0]    res_to;
  logic [WT_W-1:0]     res_wt;
  logic [TOTAL_W-1:0]  res_total;
  logic                res_valid;

  // list length memory
  logic [LW-1:0] len_mem [MAX_VERTICES];
  logic [VW-1:0] len_rd_addr;
  logic [LW-1:0] len_rd_data;
  logic          len_we;
  logic [VW-1:0] len_wr_addr;
  logic [LW-1:0] len_wr_data;

  // neighbor store
  entry_t           nbr_mem [NROW];
  logic [VW+DW-1:0] nbr_rd_addr;
  entry_t           nbr_rd_data;
  logic             nbr_we;
  logic [VW+DW-1:0] nbr_wr_addr;
  entry_t           nbr_wr_data;

  // vertex numbers as memory row indexes
  logic [XW-1:0] from_x;
  logic [XW-1:0] to_x;
  logic [VW-1:0] from_v;
  logic [VW-1:0] to_v;
  logic [VW-1:0] cur_v;
  logic [VTX_W-1:0] key_nbr;
  assign from_x  = XW'(item_from);
  assign to_x    = XW'(item_to);
  assign from_v  = from_x[VW-1:0];
  assign to_v    = to_x[VW-1:0];
  assign cur_v   = pass ? to_v : from_v;
  assign key_nbr = pass ? item_from : item_to;

  logic self_loop;
  assign self_loop = (item_from == item_to);

  // range check on the arriving item
  logic [LIMW-1:0] vc_ext;
  logic [LIMW-1:0] v_lim;
  logic            in_range;
  assign vc_ext   = LIMW'(vertex_count);
  assign v_lim    = (vc_ext < LIMW'(MAX_VERTICES)) ? vc_ext : LIMW'(MAX_VERTICES);
  assign in_range = (LIMW'(in_from) < v_lim) && (LIMW'(in_to) < v_lim);

  // add fit check, length of the to list as just read
  logic [LW:0] len_a_p2;
  logic        add_fits;
  assign len_a_p2 = {1'b0, len_a} + (LW + 1)'(2);
  assign add_fits = self_loop ? (len_a_p2 <= (LW + 1)'(MAX_DEGREE)) :
                    ((len_a < LW'(MAX_DEGREE)) && (len_rd_data < LW'(MAX_DEGREE)));

  // second append slot: the same list one further on for a self-loop
  logic [LW-1:0] add_b_len;
  assign add_b_len = self_loop ? (len_a + LW'(1)) : len_b;

  // the shared comparator: neighbor always, weight only for remove
  logic entry_match;
  assign entry_match = (nbr_rd_data.nbr == key_nbr) &&
                       ((item_mode == MODE_LOOKUP) || (nbr_rd_data.wt == item_wt));

  logic [LW-1:0] idx_inc;
  assign idx_inc = idx + LW'(1);

  logic s_fire;
  logic m_take;
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_take   = (state == S_RESULT) && (!res_valid || m_tready);

  // memory ports driven by the sequencer
  always_comb begin
    len_rd_addr = from_v;
    len_we      = 1'b0;
    len_wr_addr = from_v;
    len_wr_data = '0;
    nbr_rd_addr = {cur_v, idx[DW-1:0]};
    nbr_we      = 1'b0;
    nbr_wr_addr = {cur_v, idx[DW-1:0]};
    nbr_wr_data = nbr_rd_data;
    case (state)
      S_CLR: begin
        len_we      = 1'b1;
        len_wr_addr = clr_idx;
      end
      S_LEN_B: begin
        len_rd_addr = to_v;
      end
      S_ADD_A: begin
        len_we          = 1'b1;
        len_wr_data     = len_a + LW'(1);
        nbr_we          = 1'b1;
        nbr_wr_addr     = {from_v, len_a[DW-1:0]};
        nbr_wr_data.nbr = item_to;
        nbr_wr_data.wt  = item_wt;
      end
      S_ADD_B: begin
        len_we          = 1'b1;
        len_wr_addr     = to_v;
        len_wr_data     = add_b_len + LW'(1);
        nbr_we          = 1'b1;
        nbr_wr_addr     = {to_v, add_b_len[DW-1:0]};
        nbr_wr_data.nbr = item_from;
        nbr_wr_data.wt  = item_wt;
      end
      S_SHIFT_RD: begin
        // last slot reached: the list is one shorter
        len_we      = (idx_inc >= list_n);
        len_wr_addr = cur_v;
        len_wr_data = list_n - LW'(1);
        nbr_rd_addr = {cur_v, idx_inc[DW-1:0]};
      end
      S_SHIFT_WR: begin
        nbr_we = 1'b1;   // move the later entry down one slot
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wr_addr] <= len_wr_data;
    end
    len_rd_data <= len_mem[len_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_wr_addr] <= nbr_wr_data;
    end
    nbr_rd_data <= nbr_mem[nbr_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      clr_item  <= 1'b0;
      edge_cnt  <= '0;
      pass      <= 1'b0;
      removed   <= 1'b0;
      hit_found <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // a new result may be loaded in the cycle the old one leaves
      if (m_take) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + VW'(1);
          if (clr_idx == VW'(MAX_VERTICES - 1)) begin
            state <= clr_item ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            item_mode   <= s_tuser;
            item_from   <= in_from;
            item_to     <= in_to;
            item_wt     <= in_wt;
            pass        <= 1'b0;
            removed     <= 1'b0;
            hit_found   <= 1'b0;
            if (s_tuser == MODE_CLEAR) begin
              item_status <= ST_OK;
              edge_cnt    <= '0;
              clr_idx     <= '0;
              clr_item    <= 1'b1;
              state       <= S_CLR;
            end else if (!in_range) begin
              item_status <= ST_RANGE;
              state       <= S_RESULT;
            end else begin
              item_status <= ST_OK;
              state       <= S_LEN_A;
            end
          end
        end
        S_LEN_A: begin
          state <= S_LEN_B;
        end
        S_LEN_B: begin
          len_a <= len_rd_data;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          len_b  <= len_rd_data;
          list_n <= len_a;
          idx    <= '0;
          if (item_mode == MODE_ADD) begin
            if (add_fits) begin
              state <= S_ADD_A;
            end else begin
              item_status <= ST_FULL;
              state       <= S_RESULT;
            end
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_ADD_A: begin
          state <= S_ADD_B;
        end
        S_ADD_B: begin
          edge_cnt <= edge_cnt + TOTAL_W'(1);
          state    <= S_RESULT;
        end
        S_SCAN_RD: begin
          if (idx == list_n) begin
            if (item_mode == MODE_LOOKUP) begin
              item_status <= ST_MISS;
              state       <= S_RESULT;
            end else begin
              state <= S_NEXT_LIST;
            end
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (entry_match) begin
            if (item_mode == MODE_LOOKUP) begin
              hit_found <= 1'b1;
              hit_w     <= nbr_rd_data.wt;
              state     <= S_RESULT;
            end else begin
              removed <= 1'b1;
              state   <= S_SHIFT_RD;
            end
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          if (idx_inc >= list_n) begin
            list_n <= list_n - LW'(1);
            state  <= S_NEXT_LIST;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          idx   <= idx_inc;
          state <= S_SHIFT_RD;
        end
        S_NEXT_LIST: begin
          if (!pass) begin
            // a self-loop searches the same, possibly shortened, list again
            pass   <= 1'b1;
            idx    <= '0;
            list_n <= self_loop ? list_n : len_b;
            state  <= S_SCAN_RD;
          end else begin
            if (removed) begin
              if (edge_cnt != '0) begin
                edge_cnt <= edge_cnt - TOTAL_W'(1);
              end
            end else begin
              item_status <= ST_MISS;
            end
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (m_take) begin
            clr_item <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (m_take) begin
      res_status <= item_status;
      res_from   <= hit_found ? HIT_W'(item_from) : HIT_NONE;
      res_to     <= hit_found ? HIT_W'(item_to) : HIT_NONE;
      res_wt     <= hit_found ? hit_w : '0;
      res_total  <= edge_cnt;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {res_total, res_wt, res_to, res_from};

  // a lookup hit is always reported with ok status
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[6:0] != HIT_NONE)) |-> (m_tuser == ST_OK))
    else $error("hit fields set on a result that is not ok");

  // the edge count moves only on accept, on the second append or at the end of a remove
  assert property (@(posedge clk) disable iff (rst)
    (edge_cnt != $past(edge_cnt)) |->
      (($past(state) == S_IDLE) || ($past(state) == S_ADD_B) ||
       ($past(state) == S_NEXT_LIST)))
    else $error("edge count changed outside add, remove or clear");

  // a list being searched never holds more than the degree bound
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_RD) |-> (list_n <= LW'(MAX_DEGREE)))
    else $error("neighbor list length beyond the degree bound");

endmodule

// File: sim/adjacency_list_edge_store_tb.sv
// adjacency_list_edge_store_tb: self-checking testbench for the adjacency list edge store
// a directed table, then random add/remove/lookup/clear traffic under varied vertex counts
// depends on ales_pkg and adjacency_list_edge_store; results checked by predictor or typed table
`timescale 1ns / 1ps

module adjacency_list_edge_store_tb;
  import ales_pkg::*;

  localparam int MAX_VTX         = 64;
  localparam int MAX_DEG         = 16;
  localparam int N_ROWS          = 33;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int DRAIN_CYCLES    = 200;      // well past the slowest item
  localparam int HOLD_CYCLES     = 600;      // long receiver hold-off
  localparam int CYCLE_LIMIT     = 1000000;

  // one result item as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HIT_W-1:0]    hit_from;
    logic [HIT_W-1:0]    hit_to;
    logic [WT_W-1:0]     hit_weight;
    logic [TOTAL_W-1:0]  edge_total;
  } edge_result_t;

  // directed table row: a register write, an item checked by the predictor,
  // or an item with its result typed in
  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       mode;
    logic [5:0]       from_v;
    logic [5:0]       to_v;
    logic [31:0]      weight;   // vertex count in the low bits for a register write
    edge_result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [1:0]  s_tuser;       // mode
  logic [47:0] s_tdata;       // from_vertex[5:0], to_vertex[11:6], weight[43:12], zero
  logic        m_tvalid;
  logic        m_tready;
  logic [1:0]  m_tuser;       // status
  logic [55:0] m_tdata;       // hit_from[6:0], hit_to[13:7], hit_weight[45:14], edge_total[55:46]

  // predictor state: neighbor lists, lengths, live edge count, vertex count register
  entry_t      nbr_list [MAX_VTX][MAX_DEG];
  int unsigned nbr_len [MAX_VTX];
  logic [9:0]  live_edges;
  logic [6:0]  vcnt_model;

  edge_result_t expected_results [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 14;
  int           rx_idle_pct = 74;
  int           hold_req_cnt = 0;    // bumped by the sender side to ask for a hold-off
  int           hold_done_cnt = 0;   // bumped by the receiver when a hold-off is over

  stim_row_t   directed_rows [N_ROWS];
  logic [6:0]  phase_vcnt [N_PHASES] = '{7'd64, 7'd2, 7'd127, 7'd5, 7'd1, 7'd40};

  adjacency_list_edge_store i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tuser     (m_tuser),
    .m_tdata     (m_tdata)
  );

  always #10 clk = ~clk;

  // erase the first entry of list v matching (nbr, weight), keeping order
  function automatic bit erase_entry(input int v, input logic [5:0] nbr,
                                     input logic [31:0] weight);
    int n;
    n = nbr_len[v];
    for (int i = 0; i < n; i++) begin
      if (nbr_list[v][i].nbr == nbr && nbr_list[v][i].wt == weight) begin
        for (int j = i; j + 1 < n; j++) nbr_list[v][j] = nbr_list[v][j + 1];
        nbr_len[v] = n - 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // apply one item to the edge lists and return the result it should produce
  function automatic edge_result_t apply_edge_item(input logic [1:0] mode,
                                                   input logic [5:0] from_v,
                                                   input logic [5:0] to_v,
                                                   input logic [31:0] weight);
    edge_result_t r;
    int           lim;
    bit           fits;
    bit           gone_a;
    bit           gone_b;
    r.status     = ST_OK;
    r.hit_from   = HIT_NONE;
    r.hit_to     = HIT_NONE;
    r.hit_weight = '0;
    lim = (vcnt_model < MAX_VTX) ? int'(vcnt_model) : MAX_VTX;
    if (mode == MODE_CLEAR) begin
      // vertices are ignored
      foreach (nbr_len[v]) nbr_len[v] = 0;
      live_edges = '0;
    end else if (from_v >= lim || to_v >= lim) begin
      r.status = ST_RANGE;
    end else if (mode == MODE_ADD) begin
      // a self-loop takes two slots of the one list
      if (from_v == to_v) fits = nbr_len[from_v] + 2 <= MAX_DEG;
      else fits = nbr_len[from_v] < MAX_DEG && nbr_len[to_v] < MAX_DEG;
      if (!fits) begin
        r.status = ST_FULL;
      end else begin
        nbr_list[from_v][nbr_len[from_v]] = '{wt: weight, nbr: to_v};
        nbr_len[from_v]++;
        nbr_list[to_v][nbr_len[to_v]] = '{wt: weight, nbr: from_v};
        nbr_len[to_v]++;
        live_edges = live_edges + 10'd1;
      end
    end else if (mode == MODE_REMOVE) begin
      gone_a = erase_entry(from_v, to_v, weight);
      gone_b = erase_entry(to_v, from_v, weight);
      if (gone_a || gone_b) begin
        if (live_edges != '0) live_edges = live_edges - 10'd1;
      end else begin
        r.status = ST_MISS;
      end
    end else begin
      r.status = ST_MISS;
      for (int i = 0; i < nbr_len[from_v]; i++) begin
        if (nbr_list[from_v][i].nbr == to_v) begin
          r.status     = ST_OK;
          r.hit_from   = {1'b0, from_v};
          r.hit_to     = {1'b0, to_v};
          r.hit_weight = nbr_list[from_v][i].wt;
          break;
        end
      end
    end
    r.edge_total = live_edges;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [1:0] mode, input logic [5:0] f,
                                          input logic [5:0] t, input logic [31:0] w,
                                          input logic [1:0] st, input logic [6:0] hf,
                                          input logic [6:0] ht, input logic [31:0] hw,
                                          input logic [9:0] total);
    stim_row_t row;
    row.kind   = ROW_TYPED;
    row.mode   = mode;
    row.from_v = f;
    row.to_v   = t;
    row.weight = w;
    row.want   = '{status: st, hit_from: hf, hit_to: ht, hit_weight: hw, edge_total: total};
    return row;
  endfunction

  function automatic stim_row_t open_row(input logic [1:0] mode, input logic [5:0] f,
                                         input logic [5:0] t, input logic [31:0] w);
    stim_row_t row;
    row      = typed_row(mode, f, t, w, ST_OK, HIT_NONE, HIT_NONE, '0, '0);
    row.kind = ROW_PREDICT;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [6:0] v);
    stim_row_t row;
    row      = open_row(MODE_CLEAR, '0, '0, {25'd0, v});
    row.kind = ROW_CFG;
    return row;
  endfunction

  function automatic logic [5:0] pick_vertex(input int lim);
    // mostly in range, now and then anywhere
    if (lim > 0 && $urandom_range(9) != 0) return 6'($urandom_range(lim - 1));
    return 6'($urandom_range(63));
  endfunction

  // offer one item, wait for it to be taken, then idle at random
  task automatic send_item(input logic [1:0] mode, input logic [5:0] f, input logic [5:0] t,
                           input logic [31:0] w, input bit typed, input edge_result_t want);
    edge_result_t predicted;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'd0, w, t, f};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_edge_item(mode, f, t, w);
    expected_results.push_back(typed ? want : predicted);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // random item: mostly adds, removes of live entries and lookups of known neighbors
  task automatic send_random_item();
    logic [1:0]   mode;
    logic [5:0]   f;
    logic [5:0]   t;
    logic [5:0]   swap;
    logic [31:0]  w;
    int           lim;
    int           pick;
    int           k;
    edge_result_t none;
    none = '0;
    lim  = (vcnt_model < MAX_VTX) ? int'(vcnt_model) : MAX_VTX;
    f    = pick_vertex(lim);
    t    = pick_vertex(lim);
    case ($urandom_range(9))
      0:          w = 32'h8000_0000;
      1:          w = 32'h7FFF_FFFF;
      2, 3, 4, 5: w = 32'($urandom_range(3));   // small pool so weights repeat
      default:    w = $urandom();
    endcase
    pick = $urandom_range(99);
    if (pick < 42) begin
      mode = MODE_ADD;
    end else if (pick < 68) begin
      mode = MODE_REMOVE;
      if (nbr_len[f] != 0 && $urandom_range(9) < 8) begin
        k = $urandom_range(nbr_len[f] - 1);
        t = nbr_list[f][k].nbr;
        w = nbr_list[f][k].wt;
        if ($urandom_range(3) == 0) begin
          swap = f;
          f    = t;
          t    = swap;
        end
      end
    end else if (pick < 98) begin
      mode = MODE_LOOKUP;
      if (nbr_len[f] != 0 && $urandom_range(3) != 0)
        t = nbr_list[f][$urandom_range(nbr_len[f] - 1)].nbr;
    end else begin
      mode = MODE_CLEAR;
    end
    send_item(mode, f, t, w, 1'b0, none);
  endtask

  // register write only once the block has gone quiet
  task automatic write_vertex_count(input logic [6:0] v);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    vcnt_model = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done_cnt != hold_req_cnt) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done_cnt++;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with none expected, status %0d", m_tuser);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("hit_from", 32'(want.hit_from), 32'(m_tdata[6:0]));
        check_field("hit_to", 32'(want.hit_to), 32'(m_tdata[13:7]));
        check_field("hit_weight", want.hit_weight, m_tdata[45:14]);
        check_field("edge_total", 32'(want.edge_total), 32'(m_tdata[55:46]));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tuser     <= '0;
    s_tdata     <= '0;
    foreach (nbr_len[v]) nbr_len[v] = 0;
    live_edges = '0;
    vcnt_model = VCNT_RESET;

    directed_rows = '{
      // empty store: lookup and remove both miss
      typed_row(MODE_LOOKUP, 6'd0, 6'd0, 32'h0, ST_MISS, HIT_NONE, HIT_NONE, 32'h0, 10'd0),
      typed_row(MODE_REMOVE, 6'd5, 6'd6, 32'h0, ST_MISS, HIT_NONE, HIT_NONE, 32'h0, 10'd0),
      // extreme vertices and weights, then a lookup of that edge
      typed_row(MODE_ADD, 6'd0, 6'd63, 32'h7FFF_FFFF, ST_OK, HIT_NONE, HIT_NONE, 32'h0, 10'd1),
      typed_row(MODE_LOOKUP, 6'd0, 6'd63, 32'hFFFF_FFFF, ST_OK, 7'd0, 7'd63, 32'h7FFF_FFFF,
                10'd1),
      // self-loop on the top vertex
      typed_row(MODE_ADD, 6'd63, 6'd63, 32'h8000_0000, ST_OK, HIT_NONE, HIT_NONE, 32'h0, 10'd2),
      typed_row(MODE_LOOKUP, 6'd63, 6'd63, 32'h0, ST_OK, 7'd63, 7'd63, 32'h8000_0000, 10'd2),
      // remove with the wrong weight misses, then the real ones
      typed_row(MODE_REMOVE, 6'd0, 6'd63, 32'h0, ST_MISS, HIT_NONE, HIT_NONE, 32'h0, 10'd2),
      typed_row(MODE_REMOVE, 6'd0, 6'd63, 32'h7FFF_FFFF, ST_OK, HIT_NONE, HIT_NONE, 32'h0, 10'd1),
      typed_row(MODE_REMOVE, 6'd63, 6'd63, 32'h8000_0000, ST_OK, HIT_NONE, HIT_NONE, 32'h0,
                10'd0),
      // parallel edges with different weights, lookup takes the first
      open_row(MODE_ADD, 6'd5, 6'd9, 32'hFFFF_FFFF),
      open_row(MODE_ADD, 6'd9, 6'd5, 32'h0000_0007),
      open_row(MODE_LOOKUP, 6'd9, 6'd5, 32'h0),
      open_row(MODE_REMOVE, 6'd9, 6'd5, 32'hFFFF_FFFF),
      // clear ignores its vertices
      typed_row(MODE_CLEAR, 6'd63, 6'd63, 32'hA5A5_A5A5, ST_OK, HIT_NONE, HIT_NONE, 32'h0, 10'd0),
      typed_row(MODE_LOOKUP, 6'd5, 6'd9, 32'h0, ST_MISS, HIT_NONE, HIT_NONE, 32'h0, 10'd0),
      // zero vertex count: everything out of range, clear still works
      cfg_row(7'd0),
      typed_row(MODE_LOOKUP, 6'd0, 6'd0, 32'h0, ST_RANGE, HIT_NONE, HIT_NONE, 32'h0, 10'd0),
      typed_row(MODE_ADD, 6'd0, 6'd0, 32'h1, ST_RANGE, HIT_NONE, HIT_NONE, 32'h0, 10'd0),
      typed_row(MODE_CLEAR, 6'd0, 6'd0, 32'h0, ST_OK, HIT_NONE, HIT_NONE, 32'h0, 10'd0),
      // one vertex: fill its list with self-loops until it is full
      cfg_row(7'd1),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'h3),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'h0),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'hFFFF_FFFF),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'h3),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'h5),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'h6),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'h7),
      open_row(MODE_ADD, 6'd0, 6'd0, 32'h8),
      typed_row(MODE_ADD, 6'd0, 6'd0, 32'h4, ST_FULL, HIT_NONE, HIT_NONE, 32'h0, 10'd8),
      typed_row(MODE_LOOKUP, 6'd0, 6'd0, 32'h0, ST_OK, 7'd0, 7'd0, 32'h3, 10'd8),
      // self-loop remove erases two entries, count drops by one
      typed_row(MODE_REMOVE, 6'd0, 6'd0, 32'h3, ST_OK, HIT_NONE, HIT_NONE, 32'h0, 10'd7),
      // register above the vertex limit
      cfg_row(7'd127),
      open_row(MODE_ADD, 6'd63, 6'd1, 32'h1234_5678)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_vertex_count(directed_rows[r].weight[6:0]);
      else
        send_item(directed_rows[r].mode, directed_rows[r].from_v, directed_rows[r].to_v,
                  directed_rows[r].weight, directed_rows[r].kind == ROW_TYPED,
                  directed_rows[r].want);
    end

    // random phases: slow receiver, then slow sender, then full rate
    for (int p = 0; p < N_PHASES; p++) begin
      write_vertex_count(phase_vcnt[p]);
      tx_idle_pct = (p < 2) ? 14 : (p < 4) ? 74 : 0;
      rx_idle_pct = (p < 2) ? 74 : (p < 4) ? 14 : 0;
      // long receiver hold-off while the sender keeps offering
      if (p == 0 || p == 4) hold_req_cnt++;
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
